FILE: sv/mlba_pkg.sv
// mlba_pkg: shared types, codes and constants of the multi-level bitmap chunk allocator
// no dependencies; used by the front, queue, back and top level

package mlba_pkg;

  // register file geometry
  localparam int NREG      = 4;
  localparam int BYTES_W   = 32;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // level field of a queued command, wide enough for the largest level count
  localparam int LVL_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_L0_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L3_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L0_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L1_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_L2_COUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_L3_COUNT = 3'd7;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NONE_FREE = 2'd2;
  localparam logic [1:0] ST_FREED     = 2'd3;

  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [CNT_W-1:0]   count_t;

  // chunk sizes after reset
  localparam bytes_t RESET_BYTES [NREG] = '{32'd1024, 32'd65536, 32'd1048576, 32'd16777216};

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_TOO_LARGE,
    CMD_FREE,
    CMD_FREE_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [LVL_W-1:0] lvl;   // first fitting level, or level to free
    logic [3:0]       grp;   // word to free
    logic [5:0]       pos;   // bit to free
  } cmd_t;

endpackage

FILE: sv/mlba_if.sv
// mlba_in_if / mlba_out_if: valid-ready channels of the chunk allocator
// depends on nothing; payload widths follow the item fields

interface mlba_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] request_size;
  logic [1:0]  free_level;
  logic [3:0]  free_word;
  logic [5:0]  free_bit;

  modport source (output valid, action, request_size, free_level, free_word, free_bit,
                  input ready);
  modport sink (input valid, action, request_size, free_level, free_word, free_bit,
                output ready);
endinterface

interface mlba_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] out_level;
  logic [3:0] out_word;
  logic [5:0] out_bit;

  modport source (output valid, status, out_level, out_word, out_bit, input ready);
  modport sink (input valid, status, out_level, out_word, out_bit, output ready);
endinterface

FILE: sv/multi_level_bitmap_chunk_allocator_core.sv
// multi_level_bitmap_chunk_allocator_core: top level with configuration registers
// depends on mlba_pkg, mlba_if, mlba_front, mlba_queue and mlba_back
//
//   channel   dir  handshake          payload
//   in_ch     in   valid / ready      action, request_size, free_level, free_word, free_bit
//   out_ch    out  valid / ready      status, out_level, out_word, out_bit
//   cfg_*     in   cfg_we (no stall)  cfg_index, cfg_wdata
//
// after reset the map is cleared one word a cycle, all LEVELS * WORDS_PER_LEVEL words,
// during which requests queue up (two deep) but are not executed
// too_large and out-of-range free are answered from idle; free reads the word, then
// clears the bit and answers; allocation accepts, reads map words through the single
// read port, moves up past each level given up, then answers
// a stalled result register holds the back end; the queue takes two more beats

module multi_level_bitmap_chunk_allocator_core #(
  parameter int LEVELS          = 4,
  parameter int WORDS_PER_LEVEL = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mlba_in_if.sink                            in_ch,
  mlba_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [mlba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlba_pkg::CFG_W-1:0]         cfg_wdata
);

  mlba_pkg::bytes_t bytes_r [mlba_pkg::NREG];
  mlba_pkg::count_t count_r [mlba_pkg::NREG];

  logic           push_valid, push_ready;
  mlba_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  mlba_pkg::cmd_t pop_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mlba_pkg::NREG; i++) begin
        bytes_r[i] <= mlba_pkg::RESET_BYTES[i];
        count_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        mlba_pkg::REG_L0_BYTES: bytes_r[0] <= cfg_wdata;
        mlba_pkg::REG_L1_BYTES: bytes_r[1] <= cfg_wdata;
        mlba_pkg::REG_L2_BYTES: bytes_r[2] <= cfg_wdata;
        mlba_pkg::REG_L3_BYTES: bytes_r[3] <= cfg_wdata;
        mlba_pkg::REG_L0_COUNT: count_r[0] <= cfg_wdata[mlba_pkg::CNT_W-1:0];
        mlba_pkg::REG_L1_COUNT: count_r[1] <= cfg_wdata[mlba_pkg::CNT_W-1:0];
        mlba_pkg::REG_L2_COUNT: count_r[2] <= cfg_wdata[mlba_pkg::CNT_W-1:0];
        mlba_pkg::REG_L3_COUNT: count_r[3] <= cfg_wdata[mlba_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request classification
  mlba_front #(
    .LEVELS          (LEVELS),
    .WORDS_PER_LEVEL (WORDS_PER_LEVEL)
  ) u_front (
    .in_ch      (in_ch),
    .bytes_i    (bytes_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // command queue
  mlba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // map execution and result register
  mlba_back #(
    .LEVELS          (LEVELS),
    .WORDS_PER_LEVEL (WORDS_PER_LEVEL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .count_i   (count_r),
    .out_ch    (out_ch)
  );

endmodule

FILE: sv/mlba_front.sv
// mlba_front: accepts request beats and classifies them into back-end commands
// depends on mlba_pkg and mlba_in_if

module mlba_front #(
  parameter int LEVELS          = 4,
  parameter int WORDS_PER_LEVEL = 16
) (
  mlba_in_if.sink         in_ch,
  input  mlba_pkg::bytes_t bytes_i [mlba_pkg::NREG],
  output logic             push_valid,
  input  logic             push_ready,
  output mlba_pkg::cmd_t   push_cmd
);

  localparam int FIT_LEVELS = (LEVELS < mlba_pkg::NREG) ? LEVELS : mlba_pkg::NREG;

  logic                       fit_found;
  logic [mlba_pkg::LVL_W-1:0] fit_lvl;
  logic                       free_skip;

  // first level whose chunk size covers the request
  always_comb begin
    fit_found = 1'b0;
    fit_lvl   = '0;
    for (int i = FIT_LEVELS - 1; i >= 0; i--) begin
      if (bytes_i[i] >= in_ch.request_size) begin
        fit_found = 1'b1;
        fit_lvl   = mlba_pkg::LVL_W'(i);
      end
    end
  end

  // frees outside the map leave it alone
  assign free_skip = ({2'b00, in_ch.free_level} >= 4'(LEVELS)) ||
                     ({5'b0, in_ch.free_word} >= 9'(WORDS_PER_LEVEL));

  // command build
  always_comb begin
    push_cmd.lvl = '0;
    push_cmd.grp = in_ch.free_word;
    push_cmd.pos = in_ch.free_bit;
    if (in_ch.action) begin
      push_cmd.lvl  = mlba_pkg::LVL_W'(in_ch.free_level);
      push_cmd.kind = free_skip ? mlba_pkg::CMD_FREE_SKIP : mlba_pkg::CMD_FREE;
    end else if (fit_found) begin
      push_cmd.lvl  = fit_lvl;
      push_cmd.kind = mlba_pkg::CMD_ALLOC;
    end else begin
      push_cmd.kind = mlba_pkg::CMD_TOO_LARGE;
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

FILE: sv/mlba_queue.sv
// mlba_queue: two-entry command queue between front and back
// depends on mlba_pkg

module mlba_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mlba_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mlba_pkg::cmd_t pop_cmd
);

  mlba_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: sv/mlba_back.sv
// mlba_back: executes commands against the occupancy map and holds the result register
// depends on mlba_pkg and mlba_out_if; owns the occupancy memory

module mlba_back #(
  parameter int LEVELS          = 4,
  parameter int WORDS_PER_LEVEL = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  mlba_pkg::cmd_t   cmd,
  input  mlba_pkg::count_t count_i [mlba_pkg::NREG],
  mlba_out_if.source       out_ch
);

  localparam int DEPTH = LEVELS * WORDS_PER_LEVEL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LPW   = $clog2(LEVELS + 1);
  localparam int WCW   = $clog2(WORDS_PER_LEVEL + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE,
    S_SCAN
  } state_t;

  // flat word address of a level and word
  function automatic logic [AW-1:0] addr_of(input logic [11:0] lv, input logic [11:0] w);
    logic [11:0] a;
    a = lv * 12'(WORDS_PER_LEVEL) + w;
    return AW'(a);
  endfunction

  // words in use for a chunk count, capped at the level size
  function automatic logic [WCW-1:0] words_of(input mlba_pkg::count_t c);
    logic [11:0] r;
    r = (12'(c) + 12'd63) >> 6;
    if (r > 12'(WORDS_PER_LEVEL)) begin
      r = 12'(WORDS_PER_LEVEL);
    end
    return WCW'(r);
  endfunction

  // lowest clear bit of a word
  function automatic logic [5:0] first_zero(input logic [63:0] m);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (!m[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  // occupancy memory
  logic [63:0]   map_mem [DEPTH];
  logic [63:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [LPW-1:0]   lv_p_r, lv_p_nxt;
  logic [WCW-1:0]   w_p_r, w_p_nxt;
  logic [LPW-1:0]   lv_q_r, lv_q_nxt;
  logic [WCW-1:0]   w_q_r, w_q_nxt;
  logic             vld_q_r, vld_q_nxt;
  logic [AW-1:0]    fr_addr_r, fr_addr_nxt;
  logic [5:0]       fr_pos_r, fr_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [1:0]       out_level_r, out_level_nxt;
  logic [3:0]       out_word_r, out_word_nxt;
  logic [5:0]       out_bit_r, out_bit_nxt;

  mlba_pkg::count_t cnt_p, cnt_q;
  logic             out_free;
  logic [5:0]       zpos;
  logic             word_full;
  logic             in_bounds;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= map_mem[mem_raddr];
  end

  // chunk counts of the issue and check levels
  always_comb begin
    cnt_p = '0;
    cnt_q = '0;
    for (int i = 0; i < mlba_pkg::NREG; i++) begin
      if (i < LEVELS && int'(lv_p_r) == i) begin
        cnt_p = count_i[i];
      end
      if (i < LEVELS && int'(lv_q_r) == i) begin
        cnt_q = count_i[i];
      end
    end
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign zpos      = first_zero(rd_data_r);
  assign word_full = &rd_data_r;
  assign in_bounds = 16'({w_q_r, zpos}) < 16'(cnt_q);

  // sequencer: clear pass, direct answers, free read-modify-write, pipelined word scan
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    lv_p_nxt       = lv_p_r;
    w_p_nxt        = w_p_r;
    lv_q_nxt       = lv_q_r;
    w_q_nxt        = w_q_r;
    vld_q_nxt      = vld_q_r;
    fr_addr_nxt    = fr_addr_r;
    fr_pos_nxt     = fr_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;
    out_word_nxt   = out_word_r;
    out_bit_nxt    = out_bit_r;
    mem_we         = 1'b0;
    mem_waddr      = fr_addr_r;
    mem_wdata      = '0;
    mem_raddr      = '0;
    cmd_ready      = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          case (cmd.kind)
            mlba_pkg::CMD_ALLOC: begin
              lv_p_nxt  = LPW'(cmd.lvl);
              w_p_nxt   = '0;
              vld_q_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            mlba_pkg::CMD_TOO_LARGE: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mlba_pkg::ST_TOO_LARGE;
              out_level_nxt  = '0;
              out_word_nxt   = '0;
              out_bit_nxt    = '0;
            end
            mlba_pkg::CMD_FREE: begin
              mem_raddr   = addr_of(12'(cmd.lvl), 12'(cmd.grp));
              fr_addr_nxt = addr_of(12'(cmd.lvl), 12'(cmd.grp));
              fr_pos_nxt  = cmd.pos;
              state_nxt   = S_FREE;
            end
            mlba_pkg::CMD_FREE_SKIP: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mlba_pkg::ST_FREED;
              out_level_nxt  = '0;
              out_word_nxt   = '0;
              out_bit_nxt    = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FREE: begin
        mem_we         = 1'b1;
        mem_waddr      = fr_addr_r;
        mem_wdata      = rd_data_r & ~(64'd1 << fr_pos_r);
        out_valid_nxt  = 1'b1;
        out_status_nxt = mlba_pkg::ST_FREED;
        out_level_nxt  = '0;
        out_word_nxt   = '0;
        out_bit_nxt    = '0;
        state_nxt      = S_IDLE;
      end

      S_SCAN: begin
        if (vld_q_r && !word_full && in_bounds) begin
          // take the bit
          mem_we         = 1'b1;
          mem_waddr      = addr_of(12'(lv_q_r), 12'(w_q_r));
          mem_wdata      = rd_data_r | (64'd1 << zpos);
          out_valid_nxt  = 1'b1;
          out_status_nxt = mlba_pkg::ST_ALLOCATED;
          out_level_nxt  = 2'(lv_q_r);
          out_word_nxt   = 4'(w_q_r);
          out_bit_nxt    = zpos;
          vld_q_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end else if (vld_q_r && !word_full) begin
          // free bit past the chunk count: level full, restart at the next one
          lv_p_nxt  = lv_q_r + LPW'(1);
          w_p_nxt   = '0;
          vld_q_nxt = 1'b0;
        end else if (lv_p_r >= LPW'(LEVELS)) begin
          vld_q_nxt = 1'b0;
          if (!vld_q_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = mlba_pkg::ST_NONE_FREE;
            out_level_nxt  = '0;
            out_word_nxt   = '0;
            out_bit_nxt    = '0;
            state_nxt      = S_IDLE;
          end
        end else if (w_p_r < words_of(cnt_p)) begin
          // issue the next word read
          mem_raddr = addr_of(12'(lv_p_r), 12'(w_p_r));
          lv_q_nxt  = lv_p_r;
          w_q_nxt   = w_p_r;
          vld_q_nxt = 1'b1;
          w_p_nxt   = w_p_r + WCW'(1);
        end else begin
          // level exhausted
          lv_p_nxt  = lv_p_r + LPW'(1);
          w_p_nxt   = '0;
          vld_q_nxt = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lv_p_r       <= lv_p_nxt;
    w_p_r        <= w_p_nxt;
    lv_q_r       <= lv_q_nxt;
    w_q_r        <= w_q_nxt;
    fr_addr_r    <= fr_addr_nxt;
    fr_pos_r     <= fr_pos_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= out_level_nxt;
    out_word_r   <= out_word_nxt;
    out_bit_r    <= out_bit_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      vld_q_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      vld_q_r     <= vld_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_level = out_level_r;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.out_bit   = out_bit_r;

endmodule

FILE: tb/tb_multi_level_bitmap_chunk_allocator_core.sv
// testbench for multi_level_bitmap_chunk_allocator_core: directed and random allocate/free beats
// depends on mlba_pkg, mlba_if and the core; a scoreboard class predicts and checks each result
`timescale 1ns / 100ps

module tb_multi_level_bitmap_chunk_allocator_core;

  localparam int LEVELS = 4;
  localparam int WORDS  = 16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [mlba_pkg::CFG_IDX_W-1:0] BYTES_REG [mlba_pkg::NREG] =
    '{mlba_pkg::REG_L0_BYTES, mlba_pkg::REG_L1_BYTES,
      mlba_pkg::REG_L2_BYTES, mlba_pkg::REG_L3_BYTES};
  localparam logic [mlba_pkg::CFG_IDX_W-1:0] COUNT_REG [mlba_pkg::NREG] =
    '{mlba_pkg::REG_L0_COUNT, mlba_pkg::REG_L1_COUNT,
      mlba_pkg::REG_L2_COUNT, mlba_pkg::REG_L3_COUNT};

  typedef struct packed {
    logic        action;
    logic [31:0] req_size;
    logic [1:0]  lvl;
    logic [3:0]  word;
    logic [5:0]  pos;
  } chunk_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] level;
    logic [3:0] word;
    logic [5:0] pos;
  } grant_t;

  typedef enum {
    SHAPE_ASCENDING, SHAPE_ALL_MAX, SHAPE_ALL_MIN, SHAPE_SCRAMBLED, SHAPE_TINY, SHAPE_WORD_EDGE
  } cfg_shape_t;

  // scoreboard: own copy of the chunk map and registers, plus the grants still owed
  class alloc_scoreboard;
    mlba_pkg::bytes_t chunk_bytes [mlba_pkg::NREG];
    mlba_pkg::count_t chunk_count [mlba_pkg::NREG];
    logic [63:0]      used_map [LEVELS][WORDS];
    grant_t           grants_owed [$];
    logic [11:0]      held_chunks [$];  // {level, word, pos} of chunks currently taken
    int               errors;
    int               beats;

    function new();
      int i;
      for (i = 0; i < mlba_pkg::NREG; i++) begin
        chunk_bytes[i] = mlba_pkg::RESET_BYTES[i];
        chunk_count[i] = '0;
      end
      foreach (used_map[l, w]) used_map[l][w] = '0;
      errors = 0;
      beats  = 0;
    endfunction

    function void set_reg(logic [mlba_pkg::CFG_IDX_W-1:0] idx,
                          logic [mlba_pkg::CFG_W-1:0] data);
      int i;
      for (i = 0; i < mlba_pkg::NREG; i++) begin
        if (idx == BYTES_REG[i]) chunk_bytes[i] = data;
        else if (idx == COUNT_REG[i]) chunk_count[i] = data[mlba_pkg::CNT_W-1:0];
      end
    endfunction

    // lowest free chunk of one level; a first free bit past the count means full
    function bit claim_chunk(int lv, output logic [3:0] w, output logic [5:0] p);
      int nwords;
      int wi;
      int pi;
      logic [63:0] m;
      w = '0;
      p = '0;
      nwords = (int'(chunk_count[lv]) + 63) / 64;
      if (nwords > WORDS) nwords = WORDS;
      for (wi = 0; wi < nwords; wi++) begin
        m = used_map[lv][wi];
        if (m == '1) continue;
        pi = 0;
        while (pi < 63 && m[pi]) pi++;
        if (wi * 64 + pi >= int'(chunk_count[lv])) return 0;
        used_map[lv][wi][pi] = 1'b1;
        w = wi[3:0];
        p = pi[5:0];
        return 1;
      end
      return 0;
    endfunction

    function void note_request(chunk_req_t r);
      grant_t g;
      int first;
      int lv;
      int i;
      bit done;
      logic [3:0] w;
      logic [5:0] p;
      logic [11:0] key;
      g = '0;
      if (r.action == ACT_ALLOC) begin
        // first level, lowest index, whose chunk is big enough
        first = LEVELS;
        for (lv = LEVELS - 1; lv >= 0; lv--)
          if (chunk_bytes[lv] >= r.req_size) first = lv;
        if (first == LEVELS) begin
          g.status = mlba_pkg::ST_TOO_LARGE;
        end else begin
          g.status = mlba_pkg::ST_NONE_FREE;
          done = 0;
          for (lv = first; lv < LEVELS && !done; lv++) begin
            if (claim_chunk(lv, w, p)) begin
              done     = 1;
              g.status = mlba_pkg::ST_ALLOCATED;
              g.level  = lv[1:0];
              g.word   = w;
              g.pos    = p;
              held_chunks.push_back({lv[1:0], w, p});
            end
          end
        end
      end else begin
        used_map[r.lvl][r.word][r.pos] = 1'b0;
        key = {r.lvl, r.word, r.pos};
        for (i = 0; i < held_chunks.size(); i++) begin
          if (held_chunks[i] == key) begin
            held_chunks.delete(i);
            break;
          end
        end
        g.status = mlba_pkg::ST_FREED;
      end
      grants_owed.push_back(g);
    endfunction

    task report(string what, int exp, int got);
      $display("[%0t] beat %0d %s: expected %0d, got %0d", $time, beats, what, exp, got);
      errors++;
    endtask

    task check_grant(grant_t got);
      grant_t exp;
      beats++;
      if (grants_owed.size() == 0) begin
        report("result with nothing owed, status", -1, got.status);
      end else begin
        exp = grants_owed.pop_front();
        if (got.status !== exp.status) report("status", exp.status, got.status);
        if (got.level !== exp.level) report("out_level", exp.level, got.level);
        if (got.word !== exp.word) report("out_word", exp.word, got.word);
        if (got.pos !== exp.pos) report("out_bit", exp.pos, got.pos);
      end
    endtask

    function int pending();
      return grants_owed.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mlba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mlba_pkg::CFG_W-1:0] cfg_wdata;

  mlba_in_if  in_ch ();
  mlba_out_if out_ch ();

  alloc_scoreboard sb;
  int send_burst;
  int recv_burst;

  multi_level_bitmap_chunk_allocator_core #(
    .LEVELS(LEVELS),
    .WORDS_PER_LEVEL(WORDS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wait before the next beat: mostly random, with runs of back-to-back beats
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic chunk_req_t alloc_req(logic [31:0] bytes_wanted);
    chunk_req_t r;
    r = '0;
    r.action   = ACT_ALLOC;
    r.req_size = bytes_wanted;
    return r;
  endfunction

  function automatic chunk_req_t free_req(logic [1:0] lv, logic [3:0] w, logic [5:0] p);
    chunk_req_t r;
    r = '0;
    r.action = ACT_FREE;
    r.lvl    = lv;
    r.word   = w;
    r.pos    = p;
    return r;
  endfunction

  // random beat: allocations sized around the level sizes, frees mostly of taken chunks
  function automatic chunk_req_t random_request();
    chunk_req_t r;
    int roll;
    int lv;
    logic [11:0] key;
    r.lvl      = 2'($urandom_range(0, 3));
    r.word     = 4'($urandom_range(0, 15));
    r.pos      = 6'($urandom_range(0, 63));
    r.req_size = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      r.action = ACT_FREE;
      if (sb.held_chunks.size() > 0 && $urandom_range(0, 4) != 0) begin
        key    = sb.held_chunks[$urandom_range(0, sb.held_chunks.size() - 1)];
        r.lvl  = key[11:10];
        r.word = key[9:6];
        r.pos  = key[5:0];
      end
    end else begin
      r.action = ACT_ALLOC;
      roll = $urandom_range(0, 99);
      lv   = $urandom_range(0, mlba_pkg::NREG - 1);
      if (roll < 55) r.req_size = sb.chunk_bytes[lv] - $urandom_range(0, 2);
      else if (roll < 70) r.req_size = sb.chunk_bytes[lv] + 32'd1;
      else if (roll < 82) r.req_size = $urandom_range(0, 64);
    end
    return r;
  endfunction

  // present one beat at a falling edge and hold it until accepted
  task automatic send_request(chunk_req_t r);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= r.action;
    in_ch.request_size <= r.req_size;
    in_ch.free_level   <= r.lvl;
    in_ch.free_word    <= r.word;
    in_ch.free_bit     <= r.pos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic load_config(mlba_pkg::bytes_t b [mlba_pkg::NREG],
                             logic [mlba_pkg::CFG_W-1:0] c [mlba_pkg::NREG]);
    int i;
    for (i = 0; i < mlba_pkg::NREG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= BYTES_REG[i];
      cfg_wdata <= b[i];
      sb.set_reg(BYTES_REG[i], b[i]);
      @(negedge clk);
    end
    for (i = 0; i < mlba_pkg::NREG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= COUNT_REG[i];
      cfg_wdata <= c[i];
      sb.set_reg(COUNT_REG[i], c[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one random phase: new register settings, then random beats with a drain halfway
  task automatic run_phase(cfg_shape_t shape, int n_items);
    mlba_pkg::bytes_t b [mlba_pkg::NREG];
    logic [mlba_pkg::CFG_W-1:0] c [mlba_pkg::NREG];
    int i;
    for (i = 0; i < mlba_pkg::NREG; i++) begin
      case (shape)
        SHAPE_ALL_MAX: begin
          b[i] = '1;
          c[i] = (i == mlba_pkg::NREG - 1) ? '1 : {21'h1FFFFF, 11'd1024};
        end
        SHAPE_ALL_MIN: begin
          b[i] = '0;
          c[i] = $urandom_range(0, 1);
        end
        SHAPE_SCRAMBLED: begin
          b[i] = $urandom();
          c[i] = $urandom();
        end
        default: begin
          b[i] = (i == 0) ? mlba_pkg::bytes_t'($urandom_range(1, 4096))
                          : b[i-1] + mlba_pkg::bytes_t'($urandom_range(0, 1 << 20));
          if (shape == SHAPE_TINY) c[i] = $urandom_range(0, 8);
          else if (shape == SHAPE_WORD_EDGE)
            c[i] = 64 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
          else c[i] = $urandom_range(0, 130);
        end
      endcase
    end
    load_config(b, c);
    for (i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      send_request(random_request());
    end
    wait_drained();
    repeat (24) @(negedge clk);
  endtask

  // result side: random stalls, check every accepted beat
  initial begin
    grant_t got;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.status = out_ch.status;
      got.level  = out_ch.out_level;
      got.word   = out_ch.out_word;
      got.pos    = out_ch.out_bit;
      sb.check_grant(got);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    mlba_pkg::bytes_t b [mlba_pkg::NREG];
    logic [mlba_pkg::CFG_W-1:0] c [mlba_pkg::NREG];
    cfg_shape_t shapes [6];
    int p;
    sb = new();
    send_burst = 0;
    recv_burst = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ALLOC;
    in_ch.request_size = '0;
    in_ch.free_level = '0;
    in_ch.free_word = '0;
    in_ch.free_bit = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: every count is zero, so nothing can be taken
    send_request(alloc_req(32'd0));
    send_request(alloc_req(32'd1024));
    send_request(alloc_req(32'd16777216));
    send_request(alloc_req(32'd16777217));
    send_request(alloc_req(32'hFFFF_FFFF));
    send_request(free_req(2'd3, 4'd15, 6'd63));
    send_request(free_req(2'd0, 4'd0, 6'd0));
    wait_drained();
    repeat (24) @(negedge clk);

    // sizes out of order, a huge level two, junk above the count bits
    b = '{32'd16, 32'd64, 32'hFFFF_FFFF, 32'd32};
    c = '{32'd2, 32'd65, 32'hFFFF_FFFF, 32'd1};
    load_config(b, c);
    send_request(alloc_req(32'd16));
    send_request(alloc_req(32'd16));
    // level zero full, spills to level one
    send_request(alloc_req(32'd1));
    send_request(alloc_req(32'd17));
    send_request(alloc_req(32'd0));
    send_request(alloc_req(32'd65));
    send_request(alloc_req(32'hFFFF_FFFF));
    send_request(free_req(2'd0, 4'd0, 6'd1));
    send_request(alloc_req(32'd5));
    // free of a chunk that is already free
    send_request(free_req(2'd0, 4'd0, 6'd5));
    send_request(free_req(2'd2, 4'd0, 6'd0));
    send_request(alloc_req(32'd64));
    send_request(free_req(2'd3, 4'd15, 6'd63));
    send_request(alloc_req(32'd33));
    wait_drained();
    repeat (24) @(negedge clk);

    shapes = '{SHAPE_ASCENDING, SHAPE_ALL_MAX, SHAPE_TINY, SHAPE_SCRAMBLED,
               SHAPE_WORD_EDGE, SHAPE_ALL_MIN};
    for (p = 0; p < 6; p++) run_phase(shapes[p], 155);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
